### src/lkv_pkg.sv
package lkv_pkg;

    localparam int CAP_W  = 5;
    localparam int FUNC_W = 1;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    typedef logic [KEY_W-1:0]        key_t;
    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [CAP_W-1:0]        cap_t;

endpackage

### src/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// A get (s_func = 0) returns one result: m_found set and the stored value on
// a hit, m_found clear and all ones on a miss; a hit makes that entry most
// recent. A put (s_func = 1) returns no result: it overwrites a present key,
// fills the lowest free entry while occupancy is below cap_in_use, and
// otherwise replaces the least recent entry. cap_in_use of 0 acts as 1 and
// values above ENTRIES act as ENTRIES; lowering it never drops entries.
// Each request waits in the input register, where a single lookup and update
// pass over all entries handles it, so the cache sustains one request per
// cycle while no get is stalled; a get result passes from the input register
// to the output register that drives m_valid. The output register stalls only
// gets while a result waits on m_ready.
// Write cap_in_use through cfg_wr_en/cfg_wr_data only while idle.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  lkv_pkg::cap_t         cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  lkv_pkg::key_t         s_key,
    input  lkv_pkg::value_t       s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output lkv_pkg::value_t       m_read_value
);

    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    cap_t                     cap_reg;

    logic                     req_valid_reg;
    logic [FUNC_W-1:0]        req_func_reg;
    key_t                     req_key_reg;
    value_t                   req_value_reg;

    logic [ENTRIES-1:0]          valid_reg,  valid_next;
    logic [ENTRIES-1:0][IW-1:0]  rank_reg,   rank_next;
    key_t [ENTRIES-1:0]          key_reg;
    value_t [ENTRIES-1:0]        value_reg;
    logic [OW-1:0]               occ_reg,    occ_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg;
    value_t                   m_value_reg;

    logic                     hit;
    logic                     full;
    logic [IW-1:0]            slot;
    logic                     is_put;
    logic                     proc_fire;
    logic                     do_update;
    logic [IW-1:0]            promote_rank;

    assign is_put    = req_func_reg == FUNC_PUT;
    assign proc_fire = req_valid_reg && (is_put || !m_valid_reg || m_ready);
    assign do_update = proc_fire && (hit || is_put);
    assign s_ready   = !req_valid_reg || proc_fire;

    lkv_lookup #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .OW      (OW)
    ) u_lookup (
        .entry_valid (valid_reg),
        .entry_key   (key_reg),
        .entry_rank  (rank_reg),
        .occupancy   (occ_reg),
        .cap         (cap_reg),
        .key         (req_key_reg),
        .hit         (hit),
        .full        (full),
        .slot        (slot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_func_reg  <= s_func;
            req_key_reg   <= s_key;
            req_value_reg <= s_value;
        end
    end

    // new entry enters at rank occupancy, then gets promoted like a hit
    assign promote_rank = (hit || full) ? rank_reg[slot] : IW'(occ_reg);

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        if (do_update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) != slot && valid_reg[i] && rank_reg[i] < promote_rank) begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            rank_next[slot]  = '0;
            valid_next[slot] = 1'b1;
            if (!hit && !full) begin
                occ_next = occ_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && is_put) begin
            key_reg[slot]   <= req_key_reg;
            value_reg[slot] <= req_value_reg;
        end
    end

    always_comb begin
        if (proc_fire && !is_put) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && !is_put) begin
            m_found_reg <= hit;
            m_value_reg <= hit ? value_reg[slot] : MISS_VALUE;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_value_reg;

endmodule

### src/lkv_lookup.sv
module lkv_lookup #(
    parameter int ENTRIES = 16,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int OW      = $clog2(ENTRIES + 1)
) (
    input  logic [ENTRIES-1:0]                     entry_valid,
    input  lkv_pkg::key_t [ENTRIES-1:0]            entry_key,
    input  logic [ENTRIES-1:0][IW-1:0]             entry_rank,
    input  logic [OW-1:0]                          occupancy,
    input  lkv_pkg::cap_t                          cap,
    input  lkv_pkg::key_t                          key,
    output logic                                   hit,
    output logic                                   full,
    output logic [IW-1:0]                          slot
);

    import lkv_pkg::*;

    localparam int CMP_W = ((OW > CAP_W) ? OW : CAP_W) + 1;
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic [IW-1:0]    lru_rank;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    free_idx;
    logic [IW-1:0]    lru_idx;

    always_comb begin
        cap_ext = CMP_W'(cap);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > ENTRIES_C) begin
            cap_eff = ENTRIES_C;
        end else begin
            cap_eff = cap_ext;
        end
        full = CMP_W'(occupancy) >= cap_eff;
    end

    // least recent valid entry carries rank occupancy-1
    assign lru_rank = IW'(occupancy - OW'(1));

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (entry_valid[i] && entry_key[i] == key) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!entry_valid[i]) begin
                free_idx = IW'(i);
            end
            if (entry_valid[i] && entry_rank[i] == lru_rank) begin
                lru_idx = IW'(i);
            end
        end
    end

    always_comb begin
        if (hit) begin
            slot = hit_idx;
        end else if (full) begin
            slot = lru_idx;
        end else begin
            slot = free_idx;
        end
    end

endmodule
